/* rtl/core/aff_pkg.sv */
// Package for the 2D affine transform engine: widths, opcodes, CORDIC constants,
// the multiply-accumulate request type and the coefficient saturation helper.
// Depends on nothing; every other file of the block uses it.
package aff_pkg;

  localparam int COORD_BITS_DEF      = 24;
  localparam int COEFF_FRAC_BITS_DEF = 24;
  localparam int CORDIC_STEPS_DEF    = 16;

  localparam int COEFF_W  = 48;
  localparam int A_W      = 50;   // multiplier operand A, a coefficient or one minus a coefficient
  localparam int B_W      = 48;   // multiplier operand B, cut into digits
  localparam int DIG_W    = 16;
  localparam int ACC_W    = 100;
  localparam int OP_W     = 3;
  localparam int ANGLE_W  = 16;
  localparam int CORDIC_W = 34;

  localparam logic [OP_W-1:0] OP_RESET     = 3'd0;
  localparam logic [OP_W-1:0] OP_TRANSLATE = 3'd1;
  localparam logic [OP_W-1:0] OP_ROTATE    = 3'd2;
  localparam logic [OP_W-1:0] OP_SCALE     = 3'd3;
  localparam logic [OP_W-1:0] OP_POINT     = 3'd4;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CORDIC_W-1:0] PI_Q29          = 34'sd1686629713;
  localparam logic signed [CORDIC_W-1:0] HALF_PI_Q29     = 34'sd843314857;

  typedef logic signed [COEFF_W-1:0] coeff_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  typedef struct packed {
    logic                  start;
    acc_t                  init;
    logic signed [A_W-1:0] a1;
    logic signed [B_W-1:0] b1;
    logic signed [A_W-1:0] a2;
    logic signed [B_W-1:0] b2;
  } mac_req_t;

  function automatic logic signed [CORDIC_W-1:0] atan_q29(input logic [4:0] idx);
    logic signed [CORDIC_W-1:0] r;
    case (idx)
      5'd0:    r = 34'sd421657428;
      5'd1:    r = 34'sd248918915;
      5'd2:    r = 34'sd131521918;
      5'd3:    r = 34'sd66762579;
      5'd4:    r = 34'sd33510843;
      5'd5:    r = 34'sd16771758;
      5'd6:    r = 34'sd8387925;
      5'd7:    r = 34'sd4194219;
      5'd8:    r = 34'sd2097141;
      5'd9:    r = 34'sd1048575;
      5'd10:   r = 34'sd524288;
      5'd11:   r = 34'sd262144;
      5'd12:   r = 34'sd131072;
      5'd13:   r = 34'sd65536;
      5'd14:   r = 34'sd32768;
      5'd15:   r = 34'sd16384;
      5'd16:   r = 34'sd8192;
      5'd17:   r = 34'sd4096;
      5'd18:   r = 34'sd2048;
      5'd19:   r = 34'sd1024;
      5'd20:   r = 34'sd512;
      5'd21:   r = 34'sd256;
      5'd22:   r = 34'sd128;
      5'd23:   r = 34'sd64;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Clamp a wide signed value to the 48-bit coefficient range.
  function automatic coeff_t sat_coeff(input acc_t v);
    coeff_t r;
    if (!v[ACC_W-1] && (|v[ACC_W-2:COEFF_W-1])) begin
      r = {1'b0, {(COEFF_W-1){1'b1}}};
    end else if (v[ACC_W-1] && !(&v[ACC_W-2:COEFF_W-1])) begin
      r = {1'b1, {(COEFF_W-1){1'b0}}};
    end else begin
      r = v[COEFF_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/aff_if.sv */
// Valid/ready channel interfaces of the affine transform engine.
// Depends on aff_pkg for the opcode and angle widths.
interface aff_in_if #(
  parameter int COORD_BITS = aff_pkg::COORD_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [aff_pkg::OP_W-1:0]      opcode;
  logic signed [COORD_BITS-1:0]  arg_x;
  logic signed [COORD_BITS-1:0]  arg_y;
  logic signed [COORD_BITS-1:0]  center_x;
  logic signed [COORD_BITS-1:0]  center_y;
  logic signed [aff_pkg::ANGLE_W-1:0] angle;

  modport source (output valid, opcode, arg_x, arg_y, center_x, center_y, angle,
                  input ready);
  modport sink   (input valid, opcode, arg_x, arg_y, center_x, center_y, angle,
                  output ready);
endinterface

interface aff_out_if #(
  parameter int COORD_BITS = aff_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;

  modport source (output valid, out_x, out_y, input ready);
  modport sink   (input valid, out_x, out_y, output ready);
endinterface

/* rtl/core/aff_mac.sv */
// Shared multiply-accumulate unit: init + a1*b1 + a2*b2, one 50x17 partial product
// per cycle with a registered product stage. Depends on aff_pkg.
module aff_mac (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aff_pkg::mac_req_t req_i,
  output logic              done_o,
  output aff_pkg::acc_t     acc_o
);
  import aff_pkg::*;

  localparam int DIGS  = B_W / DIG_W;
  localparam int STEPS = 2 * DIGS;
  localparam int CW    = $clog2(STEPS + 1);
  localparam int PP_W  = A_W + DIG_W + 1;

  logic signed [A_W-1:0]  a1_q, a2_q, a_sel;
  logic signed [B_W-1:0]  b1_q, b2_q, b_sel;
  logic signed [PP_W-1:0] pp_q, pp_d;
  logic signed [DIG_W:0]  dig;
  logic [1:0]             k, sh_q;
  logic [CW-1:0]          cnt_q;
  logic                   sel_hi, busy_q, pv_q, done_q;
  acc_t                   acc_q;

  assign sel_hi = (cnt_q >= CW'(DIGS));
  assign a_sel  = sel_hi ? a2_q : a1_q;
  assign b_sel  = sel_hi ? b2_q : b1_q;
  assign k      = sel_hi ? 2'(cnt_q - CW'(DIGS)) : 2'(cnt_q);

  // Lower digits are unsigned; the top digit carries the sign of B.
  always_comb begin
    if (k == 2'(DIGS - 1)) begin
      dig = {b_sel[B_W-1], b_sel[B_W-1 -: DIG_W]};
    end else begin
      dig = {1'b0, b_sel[k*DIG_W +: DIG_W]};
    end
  end

  assign pp_d = a_sel * dig;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        pv_q   <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        pv_q  <= (cnt_q != CW'(STEPS));
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(STEPS)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a1_q  <= req_i.a1;
      b1_q  <= req_i.b1;
      a2_q  <= req_i.a2;
      b2_q  <= req_i.b2;
      acc_q <= req_i.init;
    end else begin
      if (busy_q) begin
        pp_q <= pp_d;
        sh_q <= k;
      end
      if (pv_q) begin
        acc_q <= acc_q + (ACC_W'(pp_q) <<< (DIG_W * sh_q));
      end
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

/* rtl/core/aff_cordic.sv */
// Rotation-mode CORDIC, one micro-rotation per cycle, giving cosine and sine with
// COEFF_FRAC_BITS fractional bits. Depends on aff_pkg for constants and the atan table.
module aff_cordic #(
  parameter int COEFF_FRAC_BITS = aff_pkg::COEFF_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = aff_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [aff_pkg::ANGLE_W-1:0]   angle_i,
  output logic                                 done_o,
  output aff_pkg::coeff_t                      cos_o,
  output aff_pkg::coeff_t                      sin_o
);
  import aff_pkg::*;

  localparam int IW  = $clog2(CORDIC_STEPS);
  localparam int LSH = (COEFF_FRAC_BITS >= 30) ? COEFF_FRAC_BITS - 30 : 0;
  localparam int RSH = (COEFF_FRAC_BITS < 30) ? 30 - COEFF_FRAC_BITS : 0;

  logic signed [CORDIC_W-1:0] x_q, y_q, z_q, z0, xs, ys, at, xf, yf;
  logic [IW-1:0]              i_q;
  logic                       busy_q, done_q, flip_q;
  coeff_t                     xe, ye;

  assign z0 = CORDIC_W'(angle_i) <<< 16;
  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign at = atan_q29(5'(i_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 1'b1;
        if (i_q == IW'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Angles beyond a quarter turn are folded by half a turn; the result is negated.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= CORDIC_GAIN_Q30;
      y_q <= '0;
      if (z0 > HALF_PI_Q29) begin
        z_q    <= z0 - PI_Q29;
        flip_q <= 1'b1;
      end else if (z0 < -HALF_PI_Q29) begin
        z_q    <= z0 + PI_Q29;
        flip_q <= 1'b1;
      end else begin
        z_q    <= z0;
        flip_q <= 1'b0;
      end
    end else if (busy_q) begin
      if (!z_q[CORDIC_W-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign xf = flip_q ? -x_q : x_q;
  assign yf = flip_q ? -y_q : y_q;
  assign xe = COEFF_W'(xf);
  assign ye = COEFF_W'(yf);

  assign cos_o  = (xe <<< LSH) >>> RSH;
  assign sin_o  = (ye <<< LSH) >>> RSH;
  assign done_o = done_q;

endmodule

/* rtl/core/affine_transform_2d_engine_core.sv */
// Point transform: two multiply-accumulate jobs on the shared 50x17 multiplier, then the
// output register; the result turns valid in the same cycle that ready returns. Rotate
// runs the CORDIC (one CORDIC step per cycle), then two matrix jobs and six composition jobs;
// scale runs the two matrix jobs and the six composition jobs, translate only the latter.
// Reset and unused opcodes finish in S_IDLE. One item at a time; a stalled result holds S_OUT.
// Reset (rst_ni low, asynchronous) sets the transform to identity and clears all control.
module affine_transform_2d_engine_core #(
  parameter int COORD_BITS      = aff_pkg::COORD_BITS_DEF,
  parameter int COEFF_FRAC_BITS = aff_pkg::COEFF_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = aff_pkg::CORDIC_STEPS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  aff_in_if.sink    req_i,
  aff_out_if.source rsp_o
);
  import aff_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CORDIC   = 3'd1;
  localparam logic [2:0] S_MAC_GO   = 3'd2;
  localparam logic [2:0] S_MAC_WAIT = 3'd3;
  localparam logic [2:0] S_OUT      = 3'd4;

  localparam logic [1:0] PH_MAT = 2'd0;
  localparam logic [1:0] PH_CMP = 2'd1;
  localparam logic [1:0] PH_PT  = 2'd2;

  localparam coeff_t ONE  = 48'sd1 <<< COEFF_FRAC_BITS;
  localparam acc_t   BIAS = (ACC_W'(1) <<< COEFF_FRAC_BITS) - ACC_W'(1);

  logic [2:0] state_q;
  logic [1:0] phase_q;
  logic [2:0] job_q;
  logic       out_valid_q, req_fire, rsp_fire, last_job;

  coeff_t coeff_q [6];
  coeff_t m_q [6];
  coeff_t n_q [5];
  logic signed [COORD_BITS-1:0] ax_q, ay_q, cx_q, cy_q, px_q, py_q, out_x_q, out_y_q;

  mac_req_t mreq;
  logic     mac_done, cor_done;
  acc_t     mac_acc, trunc_sum, trunc_sh;
  coeff_t   cor_cos, cor_sin, post_raw, post_floor, tx_d, ty_d, sx_d, sy_d;
  coeff_t   mr0, mr1, mr2, oc0, oc1;
  logic     rsel;
  logic [1:0] csel;
  logic signed [COORD_BITS-1:0] post_coord;
  logic [ACC_W-COORD_BITS:0]    hi_bits;

  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_fire    = rsp_o.valid && rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.out_x = out_x_q;
  assign rsp_o.out_y = out_y_q;
  assign last_job    = (job_q == ((phase_q == PH_CMP) ? 3'd5 : 3'd1));

  assign tx_d = sat_coeff(ACC_W'(req_i.arg_x) <<< COEFF_FRAC_BITS);
  assign ty_d = sat_coeff(ACC_W'(req_i.arg_y) <<< COEFF_FRAC_BITS);
  assign sx_d = sat_coeff(ACC_W'(req_i.arg_x) <<< (COEFF_FRAC_BITS - 8));
  assign sy_d = sat_coeff(ACC_W'(req_i.arg_y) <<< (COEFF_FRAC_BITS - 8));

  aff_cordic #(
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS),
    .CORDIC_STEPS    (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (req_fire && (req_i.opcode == OP_ROTATE)),
    .angle_i (req_i.angle),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  aff_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .done_o (mac_done),
    .acc_o  (mac_acc)
  );

  // Composition job j computes row j/3, column j%3 of M times the old transform.
  assign rsel = (job_q >= 3'd3);
  assign csel = rsel ? 2'(job_q - 3'd3) : 2'(job_q);
  assign mr0  = rsel ? m_q[3] : m_q[0];
  assign mr1  = rsel ? m_q[4] : m_q[1];
  assign mr2  = rsel ? m_q[5] : m_q[2];

  always_comb begin
    case (csel)
      2'd0:    begin oc0 = coeff_q[0]; oc1 = coeff_q[3]; end
      2'd1:    begin oc0 = coeff_q[1]; oc1 = coeff_q[4]; end
      default: begin oc0 = coeff_q[2]; oc1 = coeff_q[5]; end
    endcase
  end

  always_comb begin
    mreq       = '0;
    mreq.start = (state_q == S_MAC_GO);
    case (phase_q)
      PH_MAT: begin
        if (job_q == 3'd0) begin
          mreq.a1 = A_W'(ONE) - A_W'(m_q[0]);
          mreq.b1 = B_W'(cx_q);
          mreq.a2 = A_W'(m_q[3]);
          mreq.b2 = B_W'(cy_q);
        end else begin
          mreq.a1 = A_W'(ONE) - A_W'(m_q[4]);
          mreq.b1 = B_W'(cy_q);
          mreq.a2 = A_W'(m_q[1]);
          mreq.b2 = B_W'(cx_q);
        end
      end
      PH_CMP: begin
        // Adding the translation term before the floor shift gives the same result.
        mreq.init = (csel == 2'd2) ? (ACC_W'(mr2) <<< COEFF_FRAC_BITS) : '0;
        mreq.a1   = A_W'(mr0);
        mreq.b1   = oc0;
        mreq.a2   = A_W'(mr1);
        mreq.b2   = oc1;
      end
      PH_PT: begin
        if (job_q == 3'd0) begin
          mreq.init = ACC_W'(coeff_q[2]);
          mreq.a1   = A_W'(coeff_q[0]);
          mreq.a2   = A_W'(coeff_q[1]);
        end else begin
          mreq.init = ACC_W'(coeff_q[5]);
          mreq.a1   = A_W'(coeff_q[3]);
          mreq.a2   = A_W'(coeff_q[4]);
        end
        mreq.b1 = B_W'(ax_q);
        mreq.b2 = B_W'(ay_q);
      end
      default: ;
    endcase
  end

  assign post_raw   = sat_coeff(mac_acc);
  assign post_floor = sat_coeff(mac_acc >>> COEFF_FRAC_BITS);
  assign trunc_sum  = mac_acc + (mac_acc[ACC_W-1] ? BIAS : '0);
  assign trunc_sh   = trunc_sum >>> COEFF_FRAC_BITS;
  assign hi_bits    = trunc_sh[ACC_W-1:COORD_BITS-1];

  always_comb begin
    if ((&hi_bits) || !(|hi_bits)) begin
      post_coord = trunc_sh[COORD_BITS-1:0];
    end else if (trunc_sh[ACC_W-1]) begin
      post_coord = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      post_coord = {1'b0, {(COORD_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_MAT;
      job_q       <= '0;
      out_valid_q <= 1'b0;
      coeff_q     <= '{ONE, '0, '0, '0, ONE, '0};
    end else begin
      // In S_OUT the output register is refilled below when it is taken.
      if (rsp_fire && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            job_q <= '0;
            case (req_i.opcode)
              OP_RESET:     coeff_q <= '{ONE, '0, '0, '0, ONE, '0};
              OP_TRANSLATE: begin phase_q <= PH_CMP; state_q <= S_MAC_GO; end
              OP_ROTATE:    state_q <= S_CORDIC;
              OP_SCALE:     begin phase_q <= PH_MAT; state_q <= S_MAC_GO; end
              OP_POINT:     begin phase_q <= PH_PT; state_q <= S_MAC_GO; end
              default: ;
            endcase
          end
        end
        S_CORDIC: begin
          if (cor_done) begin
            phase_q <= PH_MAT;
            job_q   <= '0;
            state_q <= S_MAC_GO;
          end
        end
        S_MAC_GO: state_q <= S_MAC_WAIT;
        S_MAC_WAIT: begin
          if (mac_done) begin
            if (!last_job) begin
              job_q   <= job_q + 1'b1;
              state_q <= S_MAC_GO;
            end else begin
              case (phase_q)
                PH_MAT: begin
                  phase_q <= PH_CMP;
                  job_q   <= '0;
                  state_q <= S_MAC_GO;
                end
                PH_CMP: begin
                  coeff_q <= '{n_q[0], n_q[1], n_q[2], n_q[3], n_q[4], post_floor};
                  state_q <= S_IDLE;
                end
                default: state_q <= S_OUT;
              endcase
            end
          end
        end
        S_OUT: begin
          if (!out_valid_q || rsp_fire) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      ax_q <= req_i.arg_x;
      ay_q <= req_i.arg_y;
      cx_q <= req_i.center_x;
      cy_q <= req_i.center_y;
      if (req_i.opcode == OP_TRANSLATE) begin
        m_q <= '{ONE, '0, tx_d, '0, ONE, ty_d};
      end else if (req_i.opcode == OP_SCALE) begin
        m_q[0] <= sx_d;
        m_q[1] <= '0;
        m_q[3] <= '0;
        m_q[4] <= sy_d;
      end
    end
    if ((state_q == S_CORDIC) && cor_done) begin
      m_q[0] <= cor_cos;
      m_q[1] <= -cor_sin;
      m_q[3] <= cor_sin;
      m_q[4] <= cor_cos;
    end
    if ((state_q == S_MAC_WAIT) && mac_done) begin
      case (phase_q)
        PH_MAT: begin
          if (job_q == 3'd0) begin
            m_q[2] <= post_raw;
          end else begin
            m_q[5] <= post_raw;
          end
        end
        PH_CMP: begin
          if (job_q != 3'd5) begin
            n_q[job_q] <= post_floor;
          end
        end
        default: begin
          if (job_q == 3'd0) begin
            px_q <= post_coord;
          end else begin
            py_q <= post_coord;
          end
        end
      endcase
    end
    if ((state_q == S_OUT) && (!out_valid_q || rsp_fire)) begin
      out_x_q <= px_q;
      out_y_q <= py_q;
    end
  end

  a_mac_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (state_q == S_MAC_WAIT))
    else $error("multiply-accumulate finished outside its wait state");

  a_cordic_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_done |-> (state_q == S_CORDIC))
    else $error("CORDIC finished while the sequencer was not waiting for it");

  a_result_from_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT) && ($past(phase_q) == PH_PT))
    else $error("result transaction raised without a point transform");

endmodule

/* test/affine_transform_2d_engine_checker.sv */
`timescale 1ns / 100ps
// Checker for the affine transform engine: follows the accumulated transform,
// predicts every point result and compares it with what the block returns.
// Depends on aff_pkg and on the channel interfaces in aff_if.sv.
module affine_transform_2d_engine_checker (
  input  logic clk_i,
  input  logic rst_ni,
  aff_in_if    req,
  aff_out_if   rsp,
  output int   fail_count_o,
  output int   pending_o
);
  import aff_pkg::*;

  localparam int FRAC = COEFF_FRAC_BITS_DEF;
  localparam int CBITS = COORD_BITS_DEF;

  typedef logic signed [127:0] w128_t;
  typedef logic signed [CBITS-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  localparam w128_t C48_MAX = (w128_t'(1) <<< 47) - 1;
  localparam w128_t C48_MIN = -(w128_t'(1) <<< 47);
  localparam w128_t CRD_MAX = (w128_t'(1) <<< (CBITS - 1)) - 1;
  localparam w128_t CRD_MIN = -(w128_t'(1) <<< (CBITS - 1));
  localparam w128_t UNIT = w128_t'(1) <<< FRAC;

  coeff_t xform [6];
  coeff_t mat [6];
  point_t expected_points [$];
  longint arctan [16];

  initial begin
    arctan[0] = 421657428; arctan[1] = 248918915; arctan[2] = 131521918;
    arctan[3] = 66762579;  arctan[4] = 33510843;  arctan[5] = 16771758;
    arctan[6] = 8387925;   arctan[7] = 4194219;   arctan[8] = 2097141;
    arctan[9] = 1048575;   arctan[10] = 524288;   arctan[11] = 262144;
    arctan[12] = 131072;   arctan[13] = 65536;    arctan[14] = 32768;
    arctan[15] = 16384;
    fail_count_o = 0;
  end

  assign pending_o = expected_points.size();

  function automatic coeff_t clamp48(input w128_t v);
    if (v > C48_MAX) return coeff_t'(C48_MAX);
    if (v < C48_MIN) return coeff_t'(C48_MIN);
    return coeff_t'(v);
  endfunction

  function automatic coord_t clamp_coord(input w128_t v);
    if (v > CRD_MAX) return coord_t'(CRD_MAX);
    if (v < CRD_MIN) return coord_t'(CRD_MIN);
    return coord_t'(v);
  endfunction

  function automatic w128_t wx(input coeff_t c);
    return w128_t'(c);
  endfunction

  // One entry of new = M * old: the product sum is floored, then the offset added.
  function automatic coeff_t mix(input coeff_t m0, input coeff_t o0, input coeff_t m1,
                                 input coeff_t o1, input coeff_t offs);
    w128_t s;
    s = (wx(m0) * wx(o0) + wx(m1) * wx(o1)) >>> FRAC;
    return clamp48(s + wx(offs));
  endfunction

  task automatic apply_matrix();
    coeff_t n [6];
    n[0] = mix(mat[0], xform[0], mat[1], xform[3], '0);
    n[1] = mix(mat[0], xform[1], mat[1], xform[4], '0);
    n[2] = mix(mat[0], xform[2], mat[1], xform[5], mat[2]);
    n[3] = mix(mat[3], xform[0], mat[4], xform[3], '0);
    n[4] = mix(mat[3], xform[1], mat[4], xform[4], '0);
    n[5] = mix(mat[3], xform[2], mat[4], xform[5], mat[5]);
    for (int i = 0; i < 6; i++) xform[i] = n[i];
  endtask

  // Rotation-mode CORDIC in Q30 with the angle in Q29; outer quadrants are folded by pi.
  task automatic sin_cos(input logic signed [15:0] ang, output coeff_t cs, output coeff_t sn);
    longint x, y, z, nx;
    bit flip;
    x = longint'(CORDIC_GAIN_Q30);
    y = 0;
    z = longint'(ang) * 65536;
    flip = 0;
    if (z > longint'(HALF_PI_Q29)) begin
      z = z - longint'(PI_Q29);
      flip = 1;
    end else if (z < -longint'(HALF_PI_Q29)) begin
      z = z + longint'(PI_Q29);
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - arctan[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + arctan[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = coeff_t'(x >>> (30 - FRAC));
    sn = coeff_t'(y >>> (30 - FRAC));
  endtask

  task automatic reset_transform();
    for (int i = 0; i < 6; i++) xform[i] = '0;
    xform[0] = coeff_t'(UNIT);
    xform[4] = coeff_t'(UNIT);
  endtask

  task automatic predict(input logic [OP_W-1:0] op, input coord_t ax, input coord_t ay,
                         input coord_t cx, input coord_t cy, input logic signed [15:0] ang);
    coeff_t cs, sn;
    w128_t omc, sx, sy;
    point_t p;
    case (op)
      OP_RESET: reset_transform();
      OP_TRANSLATE: begin
        mat[0] = coeff_t'(UNIT); mat[1] = '0; mat[2] = clamp48(w128_t'(ax) * UNIT);
        mat[3] = '0; mat[4] = coeff_t'(UNIT); mat[5] = clamp48(w128_t'(ay) * UNIT);
        apply_matrix();
      end
      OP_ROTATE: begin
        sin_cos(ang, cs, sn);
        omc = UNIT - wx(cs);
        mat[0] = cs; mat[1] = -sn;
        mat[2] = clamp48(w128_t'(cx) * omc + w128_t'(cy) * wx(sn));
        mat[3] = sn; mat[4] = cs;
        mat[5] = clamp48(w128_t'(cy) * omc - w128_t'(cx) * wx(sn));
        apply_matrix();
      end
      OP_SCALE: begin
        mat[0] = clamp48(w128_t'(ax) <<< (FRAC - 8));
        mat[4] = clamp48(w128_t'(ay) <<< (FRAC - 8));
        mat[1] = '0; mat[3] = '0;
        mat[2] = clamp48((UNIT - wx(mat[0])) * w128_t'(cx));
        mat[5] = clamp48((UNIT - wx(mat[4])) * w128_t'(cy));
        apply_matrix();
      end
      OP_POINT: begin
        sx = wx(xform[0]) * w128_t'(ax) + wx(xform[1]) * w128_t'(ay) + wx(xform[2]);
        sy = wx(xform[3]) * w128_t'(ax) + wx(xform[4]) * w128_t'(ay) + wx(xform[5]);
        // Truncate toward zero rather than floor.
        if (sx < 0) sx = sx + (UNIT - 1);
        if (sy < 0) sy = sy + (UNIT - 1);
        p.x = clamp_coord(sx >>> FRAC);
        p.y = clamp_coord(sy >>> FRAC);
        expected_points.insert(expected_points.size(), p);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    point_t e;
    if (!rst_ni) begin
      reset_transform();
      expected_points.delete();
    end else begin
      if (req.valid && req.ready) begin
        predict(req.opcode, req.arg_x, req.arg_y, req.center_x, req.center_y, req.angle);
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_points.size() == 0) begin
          $error("unexpected result transaction: out_x=%0d out_y=%0d", rsp.out_x, rsp.out_y);
          fail_count_o = fail_count_o + 1;
        end else begin
          e = expected_points.pop_front();
          if (rsp.out_x !== e.x) begin
            $error("out_x mismatch: expected %0d, actual %0d", e.x, rsp.out_x);
            fail_count_o = fail_count_o + 1;
          end
          if (rsp.out_y !== e.y) begin
            $error("out_y mismatch: expected %0d, actual %0d", e.y, rsp.out_y);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

/* test/affine_transform_2d_engine_core_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the affine transform engine: clock, reset, directed and random
// transactions with random idling and back-pressure, and the final verdict.
// Depends on aff_pkg, aff_if.sv, the core and affine_transform_2d_engine_checker.
module affine_transform_2d_engine_core_tb;
  import aff_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 1400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  bit   tx_idle_on = 1;
  bit   rx_idle_on = 1;
  bit   hold_output = 0;

  aff_in_if  req_if ();
  aff_out_if rsp_if ();

  affine_transform_2d_engine_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  affine_transform_2d_engine_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_if),
    .rsp          (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    req_if.valid    <= 1'b0;
    req_if.opcode   <= OP_RESET;
    req_if.arg_x    <= '0;
    req_if.arg_y    <= '0;
    req_if.center_x <= '0;
    req_if.center_y <= '0;
    req_if.angle    <= '0;
    rsp_if.ready    <= 1'b0;
  end

  // Result side: a random stall before each transaction when enabled, or a long hold when asked.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_output) begin
        rsp_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_output = 0;
      end
      gap = rx_idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
    end
  end

  task automatic send(input logic [OP_W-1:0] op, input int ax, input int ay,
                      input int cx, input int cy, input int ang);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.opcode   <= op;
    req_if.arg_x    <= ax[23:0];
    req_if.arg_y    <= ay[23:0];
    req_if.center_x <= cx[23:0];
    req_if.center_y <= cy[23:0];
    req_if.angle    <= ang[15:0];
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  function automatic int any24();
    return int'($urandom);
  endfunction

  function automatic int near(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int any_angle();
    return int'($urandom);
  endfunction

  initial begin
    int k, draw, npts;
    logic [OP_W-1:0] op;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identity, every opcode, angle fold boundaries and saturation.
    send(OP_POINT, 8388607, -8388608, 0, 0, 0);
    send(OP_POINT, -8388608, 8388607, 0, 0, 0);
    send(OP_TRANSLATE, 8388607, -8388608, 0, 0, 0);
    send(OP_POINT, 5, -5, 0, 0, 0);
    send(OP_TRANSLATE, 8388607, 8388607, 0, 0, 0);
    send(OP_POINT, 8388607, -8388608, 0, 0, 0);
    send(OP_RESET, 0, 0, 0, 0, 0);
    send(OP_ROTATE, 0, 0, 100, -100, 12867);
    send(OP_ROTATE, 0, 0, -100, 100, 12868);
    send(OP_ROTATE, 0, 0, 8388607, -8388608, -12868);
    send(OP_POINT, 1000, 2000, 0, 0, 0);
    send(OP_ROTATE, 0, 0, -8388608, 8388607, 32767);
    send(OP_ROTATE, 0, 0, 0, 0, -32768);
    send(OP_POINT, -3, 7, 0, 0, 0);
    send(OP_RESET, 0, 0, 0, 0, 0);
    send(OP_SCALE, 0, -256, 8388607, -8388608, 0);
    send(OP_POINT, 123, -456, 0, 0, 0);
    send(OP_RESET, 0, 0, 0, 0, 0);
    send(OP_SCALE, 8388607, -8388608, -8388608, 8388607, 0);
    send(OP_SCALE, 8388607, 8388607, 1, 1, 0);
    send(OP_POINT, -1, 1, 0, 0, 0);
    send(3'd5, 1, 2, 3, 4, 5);
    send(3'd6, -1, -1, -1, -1, -1);
    send(3'd7, 0, 0, 0, 0, 0);
    send(OP_RESET, 0, 0, 0, 0, 0);
    drain();

    // Random: rounds of a reset, up to three mostly moderate compositions and one to six points.
    k = 0;
    while (k < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) tx_idle_on = ~tx_idle_on;
      if ($urandom_range(0, 9) == 0) rx_idle_on = ~rx_idle_on;
      if (k > 400 && k < 420) hold_output = 1;
      if (k > 800 && k < 820) drain();
      send(OP_RESET, any24(), any24(), any24(), any24(), any_angle());
      k++;
      repeat ($urandom_range(0, 3)) begin
        draw = $urandom_range(0, 9);
        op = (draw < 3) ? OP_TRANSLATE : (draw < 6) ? OP_ROTATE : OP_SCALE;
        if (draw == 9) send(op, any24(), any24(), any24(), any24(), any_angle());
        else if (op == OP_SCALE)
          send(op, near(512), near(512), near(2000), near(2000), any_angle());
        else send(op, near(5000), near(5000), near(5000), near(5000), any_angle());
        k++;
      end
      npts = $urandom_range(1, 6);
      repeat (npts) begin
        if ($urandom_range(0, 3) == 0)
          send(OP_POINT, any24(), any24(), any24(), any24(), any_angle());
        else send(OP_POINT, near(10000), near(10000), any24(), any24(), any_angle());
        k++;
      end
      if ($urandom_range(0, 19) == 0) begin
        send(3'($urandom_range(5, 7)), any24(), any24(), any24(), any24(), any_angle());
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/aff_pkg.sv
rtl/core/aff_if.sv
rtl/core/aff_mac.sv
rtl/core/aff_cordic.sv
rtl/core/affine_transform_2d_engine_core.sv
test/affine_transform_2d_engine_checker.sv
test/affine_transform_2d_engine_core_tb.sv
